// ----- rtl/pru_pkg.sv -----
// package for the pixel replication upscaler
// register codes, widths and the flag word carried with each output pixel
// no dependencies
package pru_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 100;

  localparam int PIXEL_W  = 24;
  localparam int SCALE_W  = 7;
  localparam int SWIDTH_W = 11;
  localparam int HEIGHT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE         = 2'd0,
    REG_SOURCE_WIDTH  = 2'd1,
    REG_SOURCE_HEIGHT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       image_end;
  } emit_flags_t;

endpackage

// ----- rtl/pru_line_store.sv -----
// line store: one source row of pixels in a synchronous single-clock ram
// one write port, one read port with registered read data; uses pru_pkg
module pru_line_store import pru_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_WIDTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [PIXEL_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [PIXEL_W-1:0] rd_data
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/pru_sequencer.sv -----
// row sequencer: load and emit counters, store write and read requests
// computes the flags of each emitted pixel; uses pru_pkg
module pru_sequencer import pru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE,
  parameter int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int LCOL_W = $clog2(MAX_WIDTH + 1),
  parameter int SCNT_W = $clog2(MAX_SCALE + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  logic [PIXEL_W-1:0]  pixel_in,
  input  logic [SCALE_W-1:0]  scale,
  input  logic [SWIDTH_W-1:0] source_width,
  input  logic [HEIGHT_W-1:0] source_height,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [PIXEL_W-1:0]  wr_data,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  output emit_flags_t         flags
);

  logic                emitting, emitting_next;
  logic [LCOL_W-1:0]   load_column, load_column_next;
  logic [ADDR_W-1:0]   emit_column, emit_column_next;
  logic [SCNT_W-1:0]   repeat_in_row, repeat_in_row_next;
  logic [SCNT_W-1:0]   row_repeat, row_repeat_next;
  logic [HEIGHT_W-1:0] source_row, source_row_next;

  logic [LCOL_W-1:0]   w_eff;
  logic [SCNT_W-1:0]   s_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [LCOL_W-1:0]   load_inc;
  logic [LCOL_W-1:0]   col;
  logic [LCOL_W-1:0]   col_inc;
  logic                last_rep, last_col, last_row_rep, last_src_row;
  logic [3:0]          pad_prod;

  // clamp the registers to their working ranges
  always_comb begin
    if (source_width == '0) begin
      w_eff = LCOL_W'(1);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      w_eff = LCOL_W'(MAX_WIDTH);
    end else begin
      w_eff = LCOL_W'(source_width);
    end
    if (scale == '0) begin
      s_eff = SCNT_W'(1);
    end else if (32'(scale) > 32'(MAX_SCALE)) begin
      s_eff = SCNT_W'(MAX_SCALE);
    end else begin
      s_eff = SCNT_W'(scale);
    end
    h_eff = (source_height == '0) ? HEIGHT_W'(1) : source_height;
  end

  always_comb begin
    load_inc     = load_column + LCOL_W'(1);
    col          = (LCOL_W'(emit_column) >= w_eff) ? (w_eff - LCOL_W'(1))
                                                   : LCOL_W'(emit_column);
    col_inc      = col + LCOL_W'(1);
    last_rep     = (SCNT_W'(repeat_in_row + SCNT_W'(1)) >= s_eff);
    last_col     = (col_inc >= w_eff);
    last_row_rep = (SCNT_W'(row_repeat + SCNT_W'(1)) >= s_eff);
    last_src_row = ({1'b0, source_row} + 17'd1 >= {1'b0, h_eff});
    // only the low two bits of width and scale matter mod 4
    pad_prod     = w_eff[1:0] * s_eff[1:0];

    emitting_next      = emitting;
    load_column_next   = load_column;
    emit_column_next   = emit_column;
    repeat_in_row_next = repeat_in_row;
    row_repeat_next    = row_repeat;
    source_row_next    = source_row;

    wr_en   = 1'b0;
    wr_addr = ADDR_W'(load_column);
    wr_data = pixel_in;
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(col);
    flags   = '0;

    if (accept && !emitting && !kind) begin
      wr_en = (load_column < w_eff);
      if (load_inc >= w_eff) begin
        load_column_next   = '0;
        emit_column_next   = '0;
        repeat_in_row_next = '0;
        row_repeat_next    = '0;
        emitting_next      = 1'b1;
      end else begin
        load_column_next = load_inc;
      end
    end else if (accept && emitting && kind) begin
      rd_en = 1'b1;
      if (!last_rep) begin
        repeat_in_row_next = repeat_in_row + SCNT_W'(1);
      end else begin
        repeat_in_row_next = '0;
        if (!last_col) begin
          emit_column_next = ADDR_W'(col_inc);
        end else begin
          emit_column_next = '0;
          flags.row_end    = 1'b1;
          flags.pad_bytes  = pad_prod[1:0];
          if (last_row_rep) begin
            row_repeat_next  = '0;
            emitting_next    = 1'b0;
            load_column_next = '0;
            if (last_src_row) begin
              source_row_next = '0;
              flags.image_end = 1'b1;
            end else begin
              source_row_next = source_row + HEIGHT_W'(1);
            end
          end else begin
            row_repeat_next = row_repeat + SCNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting      <= 1'b0;
      load_column   <= '0;
      emit_column   <= '0;
      repeat_in_row <= '0;
      row_repeat    <= '0;
      source_row    <= '0;
    end else begin
      emitting      <= emitting_next;
      load_column   <= load_column_next;
      emit_column   <= emit_column_next;
      repeat_in_row <= repeat_in_row_next;
      row_repeat    <= row_repeat_next;
      source_row    <= source_row_next;
    end
  end

endmodule

// ----- rtl/pixel_replication_upscaler.sv -----
// top level of the pixel replication upscaler
// holds the registers and the output pipeline; uses pru_pkg, pru_sequencer, pru_line_store

// Integer nearest-neighbour upscaler. Load words (kind 0) fill a line store with one
// source row; once the row is in, each tick word (kind 1) yields one output pixel,
// each source pixel repeated scale times across the row and the row repeated scale
// times, then loading of the next row resumes. Words may follow back to back while
// in_stall is low: the line store is read once per tick and its registered read
// data moves on to the output register when that is free or being taken. Loads
// during emitting and ticks during loading are taken and dropped. The last pixel
// of an output row carries row_end and the padding count (width * scale) mod 4;
// the last pixel of the image carries image_end. The user must write registers
// only while the block is idle; the block itself does not enforce this.
module pixel_replication_upscaler import pru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [PIXEL_W-1:0]    pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_W-1:0]    pixel_out,
  output logic                  row_end,
  output logic [1:0]            pad_bytes,
  output logic                  image_end
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [SCALE_W-1:0]  scale;
  logic [SWIDTH_W-1:0] source_width;
  logic [HEIGHT_W-1:0] source_height;

  logic               accept;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [PIXEL_W-1:0] wr_data, rd_data;
  emit_flags_t        flags;

  logic               s1_valid;
  emit_flags_t        s1_flags;
  logic               s1_adv;
  logic               o_valid;
  logic [PIXEL_W-1:0] o_pixel;
  emit_flags_t        o_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= SCALE_W'(1);
      source_width  <= SWIDTH_W'(1);
      source_height <= HEIGHT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE:         scale         <= cfg_data[SCALE_W-1:0];
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SWIDTH_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // a read in flight moves on when the output register is free or being taken
  assign s1_adv   = !o_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  pru_sequencer #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (kind),
    .pixel_in      (pixel_in),
    .scale         (scale),
    .source_width  (source_width),
    .source_height (source_height),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .flags         (flags)
  );

  pru_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_flags <= flags;
    end
    if (s1_adv && s1_valid) begin
      o_pixel <= rd_data;
      o_flags <= s1_flags;
    end
  end

  assign out_valid = o_valid;
  assign pixel_out = o_pixel;
  assign row_end   = o_flags.row_end;
  assign pad_bytes = o_flags.pad_bytes;
  assign image_end = o_flags.image_end;

endmodule
